// File: design/lcgshuf_pkg.sv
// ----------------------------------------------------------------------------
// lcgshuf_pkg
// Shared constants and controller/datapath types for the combined generator.
// ----------------------------------------------------------------------------
package lcgshuf_pkg;

  // generator a
  localparam logic [30:0] MOD_A = 31'd2147483563;
  localparam logic [15:0] MUL_A = 16'd40014;
  localparam logic [15:0] QUO_A = 16'd53668;
  localparam logic [15:0] REM_A = 16'd12211;
  localparam logic [31:0] RCP_A = 32'((64'd1 << 47) / 64'd53668);

  // generator b
  localparam logic [30:0] MOD_B = 31'd2147483399;
  localparam logic [15:0] MUL_B = 16'd40692;
  localparam logic [15:0] QUO_B = 16'd52774;
  localparam logic [15:0] REM_B = 16'd3791;
  localparam logic [31:0] RCP_B = 32'((64'd1 << 47) / 64'd52774);

  localparam int unsigned RCP_SHIFT = 47;

  localparam logic [30:0] MOD_A_LESS = 31'd2147483562;
  localparam logic [31:0] FRAC_MAX   = 32'd4294966780;

  // 2^32 = 2*MOD_A + FRAC_K and 2^31 = MOD_A + FRAC_C
  localparam logic [7:0]  FRAC_K = 8'd170;
  localparam logic [7:0]  FRAC_C = 8'd85;

  localparam logic [2:0]  LEHMER_LAT = 3'd4;
  localparam int unsigned WARM_EXTRA = 8;

  localparam logic REQ_RESEED = 1'b0;
  localparam logic REQ_DRAW   = 1'b1;

  typedef struct packed {
    logic load_seed;
    logic seed_one;
    logic use_slot;
    logic warm_commit;
    logic draw_commit;
    logic out_load;
  } lcgshuf_cmd_t;

  typedef struct packed {
    logic j_last;
    logic out_free;
  } lcgshuf_sts_t;

endpackage

// File: design/lcgshuf_ram.sv
// ----------------------------------------------------------------------------
// lcgshuf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lcgshuf_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lcgshuf_lehmer.sv
// ----------------------------------------------------------------------------
// lcgshuf_lehmer
// Four-stage pipelined Schrage step, y = a*(x mod q) - floor(x/q)*r (+m if negative).
// ----------------------------------------------------------------------------
module lcgshuf_lehmer (
  input  logic        clk_i,
  input  logic        sel_b_i,
  input  logic [30:0] x_i,
  output logic [30:0] y_o
);

  logic [30:0] m;
  logic [15:0] a;
  logic [15:0] q;
  logic [15:0] rr;
  logic [31:0] rcp;

  logic [62:0] prod1;
  logic [30:0] x1_q;
  logic [15:0] k0_q;

  logic [31:0] kq;
  logic [31:0] r0;
  logic [16:0] r0_q;
  logic [15:0] k1_q;

  logic        fix;
  logic [16:0] r;
  logic [15:0] k;
  logic [31:0] ar_q;
  logic [31:0] krr_q;

  logic [32:0] dy;
  logic [32:0] y;
  logic [30:0] y_q;

  always_comb begin
    if (sel_b_i) begin
      m   = lcgshuf_pkg::MOD_B;
      a   = lcgshuf_pkg::MUL_B;
      q   = lcgshuf_pkg::QUO_B;
      rr  = lcgshuf_pkg::REM_B;
      rcp = lcgshuf_pkg::RCP_B;
    end else begin
      m   = lcgshuf_pkg::MOD_A;
      a   = lcgshuf_pkg::MUL_A;
      q   = lcgshuf_pkg::QUO_A;
      rr  = lcgshuf_pkg::REM_A;
      rcp = lcgshuf_pkg::RCP_A;
    end
  end

  // quotient estimate by reciprocal, one low at most
  assign prod1 = 63'(x_i) * 63'(rcp);
  assign kq    = 32'(k0_q) * 32'(q);
  assign r0    = 32'(x1_q) - kq;

  assign fix = (r0_q >= 17'(q));
  assign r   = fix ? (r0_q - 17'(q)) : r0_q;
  assign k   = k1_q + 16'(fix);

  assign dy = {2'b00, ar_q[30:0]} - {1'b0, krr_q};
  assign y  = dy[32] ? (dy + 33'(m)) : dy;

  always_ff @(posedge clk_i) begin
    x1_q  <= x_i;
    k0_q  <= prod1[lcgshuf_pkg::RCP_SHIFT +: 16];
    r0_q  <= r0[16:0];
    k1_q  <= k0_q;
    ar_q  <= 32'(a) * 32'(r[15:0]);
    krr_q <= 32'(k) * 32'(rr);
    y_q   <= y[30:0];
  end

  assign y_o = y_q;

endmodule

// File: design/lcgshuf_ctrl.sv
// ----------------------------------------------------------------------------
// lcgshuf_ctrl
// Sequencer for boot fill, reseed warm-up and draws.
// ----------------------------------------------------------------------------
module lcgshuf_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_kind_i,
  output logic                      in_ready_o,
  output lcgshuf_pkg::lcgshuf_cmd_t cmd_o,
  input  lcgshuf_pkg::lcgshuf_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_BOOT,
    S_IDLE,
    S_WAIT,
    S_COMMIT,
    S_FRAC,
    S_OUT
  } state_e;

  state_e     state_q;
  logic       draw_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
      draw_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_BOOT: begin
          draw_q  <= 1'b0;
          cnt_q   <= lcgshuf_pkg::LEHMER_LAT;
          state_q <= S_WAIT;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            draw_q  <= (in_kind_i == lcgshuf_pkg::REQ_DRAW);
            cnt_q   <= lcgshuf_pkg::LEHMER_LAT;
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          cnt_q <= cnt_q - 3'd1;
          if (cnt_q == 3'd1) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (draw_q) begin
            state_q <= S_FRAC;
          end else if (sts_i.j_last) begin
            state_q <= S_IDLE;
          end else begin
            cnt_q   <= lcgshuf_pkg::LEHMER_LAT;
            state_q <= S_WAIT;
          end
        end
        S_FRAC: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_BOOT;
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.load_seed   = (state_q == S_BOOT) ||
                        ((state_q == S_IDLE) && in_valid_i &&
                         (in_kind_i == lcgshuf_pkg::REQ_RESEED));
    cmd_o.seed_one    = (state_q == S_BOOT);
    cmd_o.use_slot    = draw_q;
    cmd_o.warm_commit = (state_q == S_COMMIT) && !draw_q;
    cmd_o.draw_commit = (state_q == S_COMMIT) && draw_q;
    cmd_o.out_load    = (state_q == S_OUT) && sts_i.out_free;
  end

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_wait_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> $past(state_q == S_WAIT, 1) && $past(state_q == S_WAIT, 4))
    else $error("commit without full pipeline wait");

  a_draw_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.draw_commit |=> ##1 (state_q == S_OUT))
    else $error("draw commit not followed by output stage");

endmodule

// File: design/lcgshuf_dp.sv
// ----------------------------------------------------------------------------
// lcgshuf_dp
// Generator states, shuffle table, slot and fraction arithmetic, output word.
// ----------------------------------------------------------------------------
module lcgshuf_dp #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lcgshuf_pkg::lcgshuf_cmd_t cmd_i,
  output lcgshuf_pkg::lcgshuf_sts_t sts_o,
  input  logic [31:0]               seed_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [63:0]               out_data_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned J_W   = $clog2(TABLE_DEPTH + lcgshuf_pkg::WARM_EXTRA);
  localparam logic [J_W-1:0] J_INIT =
    J_W'(TABLE_DEPTH + lcgshuf_pkg::WARM_EXTRA - 1);
  localparam logic [J_W-1:0] J_DEPTH = J_W'(TABLE_DEPTH);
  localparam logic [30:0] SLOT_DIV = 31'(1 + 2147483562 / TABLE_DEPTH);
  localparam logic [31:0] SLOT_RCP = 32'((64'd1 << 40) / 64'(SLOT_DIV));

  logic [30:0]    gen_a_q;
  logic [30:0]    gen_b_q;
  logic [30:0]    last_q;
  logic [J_W-1:0] j_q;

  logic [30:0]    seed31;
  logic [30:0]    ya;
  logic [30:0]    yb;

  // slot pipeline
  logic [62:0]      sprod;
  logic [30:0]      lo1_q;
  logic [IDX_W-1:0] s0_q;
  logic [31:0]      srem;
  logic [IDX_W-1:0] slot_q;

  // table
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [30:0]      ram_rdata;

  logic [31:0] diff;
  logic        wrap;
  logic [30:0] last_new;

  // fraction
  logic [30:0] v_q;
  logic [38:0] p_q;
  logic [7:0]  q0;
  logic [31:0] frem;
  logic        fadj;
  logic [32:0] frac33;
  logic [31:0] frac;

  logic        out_valid_q;
  logic [30:0] out_int_q;
  logic [31:0] out_frac_q;

  assign seed31 = (cmd_i.seed_one || seed_i[31] || (seed_i == 32'd0)) ? 31'd1
                                                                       : seed_i[30:0];

  lcgshuf_lehmer u_gen_a (
    .clk_i   (clk_i),
    .sel_b_i (1'b0),
    .x_i     (gen_a_q),
    .y_o     (ya)
  );

  lcgshuf_lehmer u_gen_b (
    .clk_i   (clk_i),
    .sel_b_i (1'b1),
    .x_i     (gen_b_q),
    .y_o     (yb)
  );

  assign sprod = 63'(last_q) * 63'(SLOT_RCP);
  assign srem  = 32'(lo1_q) - (32'(s0_q) * 32'(SLOT_DIV));

  always_ff @(posedge clk_i) begin
    lo1_q  <= last_q;
    s0_q   <= sprod[40 +: IDX_W];
    slot_q <= s0_q + IDX_W'(srem >= 32'(SLOT_DIV));
  end

  assign ram_we   = cmd_i.draw_commit || (cmd_i.warm_commit && (j_q < J_DEPTH));
  assign ram_addr = cmd_i.use_slot ? slot_q : j_q[IDX_W-1:0];

  lcgshuf_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ya),
    .rdata_o (ram_rdata)
  );

  assign diff     = {1'b0, ram_rdata} - {1'b0, yb};
  assign wrap     = diff[31] || (diff == 32'd0);
  assign last_new = wrap ? 31'(diff + {1'b0, lcgshuf_pkg::MOD_A_LESS}) : diff[30:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seed) begin
      gen_a_q <= seed31;
      gen_b_q <= seed31;
    end else if (cmd_i.warm_commit) begin
      gen_a_q <= ya;
    end else if (cmd_i.draw_commit) begin
      gen_a_q <= ya;
      gen_b_q <= yb;
    end
    if (cmd_i.warm_commit && (j_q == '0)) begin
      last_q <= ya;
    end else if (cmd_i.draw_commit) begin
      last_q <= last_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else if (cmd_i.load_seed) begin
      j_q <= J_INIT;
    end else if (cmd_i.warm_commit && (j_q != '0)) begin
      j_q <= j_q - J_W'(1);
    end
  end

  // frac = 2v + floor(170v / m)
  assign q0     = p_q[38:31];
  assign frem   = 32'(p_q[30:0]) + (32'(q0) * 32'(lcgshuf_pkg::FRAC_C));
  assign fadj   = (frem >= 32'(lcgshuf_pkg::MOD_A));
  assign frac33 = {1'b0, v_q, 1'b0} + 33'(q0) + 33'(fadj);
  assign frac   = (frac33 > 33'(lcgshuf_pkg::FRAC_MAX)) ? lcgshuf_pkg::FRAC_MAX
                                                         : frac33[31:0];

  always_ff @(posedge clk_i) begin
    v_q <= last_q;
    p_q <= 39'(last_q) * 39'(lcgshuf_pkg::FRAC_K);
    if (cmd_i.out_load) begin
      out_int_q  <= v_q;
      out_frac_q <= frac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.j_last   = (j_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {1'b0, out_frac_q, out_int_q};

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.draw_commit |=> (last_q != 31'd0) && (last_q <= lcgshuf_pkg::MOD_A_LESS))
    else $error("combined output out of range");

  a_warm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.draw_commit |-> (j_q == '0))
    else $error("draw while warm-up still running");

  a_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_int_q != 31'd0) && (out_frac_q <= lcgshuf_pkg::FRAC_MAX))
    else $error("output word out of range");

  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.draw_commit |-> (32'(slot_q) < 32'(TABLE_DEPTH)))
    else $error("shuffle slot beyond table");

endmodule

// File: design/combined_lcg_shuffle_rng_unit.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_unit
// Combined two-generator congruential RNG with a shuffle table.
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_axis   in   tuser: req_type[0]; tdata: seed_value[31:0]
// m_axis   out  tdata: rand_int[30:0], rand_fraction[62:31], zero[63]
//
// a draw passes the Lehmer wait, the commit, the fraction step and the output stage
// a reseed loads both generators, then runs TABLE_DEPTH+8 warm-up steps of generator a
// each step waits out the four-stage Lehmer pipeline, then commits
// after reset the table fills as for seed 1, with tready low
// a waiting result word does not block the next accept
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_unit #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // seed_value[31:0]
  input  logic        s_axis_tuser,   // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // rand_int[30:0], rand_fraction[62:31]
);

  lcgshuf_pkg::lcgshuf_cmd_t cmd;
  lcgshuf_pkg::lcgshuf_sts_t sts;

  lcgshuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lcgshuf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .seed_i      (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: bench/tb_combined_lcg_shuffle_rng_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_combined_lcg_shuffle_rng_unit
// Self-checking bench for the combined two-generator RNG with shuffle table.
// A queue of reseed and draw requests feeds a stream driver. A monitor keeps a
// bit-true copy of both Lehmer generators, the shuffle table and the previous
// output, predicts each draw and compares every result word field by field.
// Directed seeds cover clamping, both moduli and the extremes. Random traffic
// follows under three sender/receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_combined_lcg_shuffle_rng_unit;

  localparam int unsigned TAB_DEPTH   = 32;
  localparam int          N_RANDOM    = 1028;
  localparam int          WATCH_LIMIT = 3000;
  localparam int          TAIL_CYCLES = 40;

  localparam longint GA_MOD = 64'd2147483563;
  localparam longint GB_MOD = 64'd2147483399;
  localparam longint GA_MUL = 40014;
  localparam longint GB_MUL = 40692;
  localparam longint GA_QUO = 53668;
  localparam longint GB_QUO = 52774;
  localparam longint GA_REM = 12211;
  localparam longint GB_REM = 3791;
  localparam longint OUT_TOP  = 64'd2147483562;
  localparam longint SLOT_DIV = 1 + OUT_TOP / TAB_DEPTH;
  localparam logic [63:0] FRAC_SAT = 64'd4294966780;

  typedef struct {
    logic        req;
    logic [31:0] seed;
    bit          hold;
  } rng_req_t;

  typedef struct {
    logic [30:0] rand_int;
    logic [31:0] rand_frac;
  } rng_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  rng_req_t  req_q[$];
  rng_word_t predicted_rand_q[$];

  longint gen_a, gen_b, prev_out;
  longint shuf_tab[TAB_DEPTH];

  int words_sent     = 0;
  int draws_issued   = 0;
  int reseeds_issued = 0;
  int words_got      = 0;
  int err_cnt        = 0;
  int quiet_cycles   = 0;
  bit timed_out      = 1'b0;

  combined_lcg_shuffle_rng_unit #(
    .TABLE_DEPTH(TAB_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint lehmer_next(longint x, longint mul, longint quo,
                                         longint rm, longint md);
    longint k, y;
    k = x / quo;
    y = mul * (x - k * quo) - k * rm;
    if (y < 0) y += md;
    return y;
  endfunction

  function automatic void rng_reseed(logic signed [31:0] seed_in);
    longint seed;
    int j;
    seed = seed_in;
    if (seed < 1) seed = 1;
    gen_a = seed;
    gen_b = seed;
    for (j = TAB_DEPTH + 7; j >= 0; j--) begin
      gen_a = lehmer_next(gen_a, GA_MUL, GA_QUO, GA_REM, GA_MOD);
      if (j < TAB_DEPTH) shuf_tab[j] = gen_a;
    end
    prev_out = shuf_tab[0];
  endfunction

  function automatic rng_word_t rng_draw();
    rng_word_t w;
    longint slot;
    logic [63:0] frac;
    gen_a = lehmer_next(gen_a, GA_MUL, GA_QUO, GA_REM, GA_MOD);
    gen_b = lehmer_next(gen_b, GB_MUL, GB_QUO, GB_REM, GB_MOD);
    slot = (prev_out / SLOT_DIV) % TAB_DEPTH;
    if (slot < 0) slot = 0;
    prev_out = shuf_tab[slot] - gen_b;
    shuf_tab[slot] = gen_a;
    if (prev_out < 1) prev_out += OUT_TOP;
    frac = (64'(prev_out) << 32) / 64'(GA_MOD);
    if (frac > FRAC_SAT) frac = FRAC_SAT;
    w.rand_int  = prev_out[30:0];
    w.rand_frac = frac[31:0];
    return w;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got,
                                 longint unsigned want);
    $display("%0t mismatch word %0d %s: got %0d want %0d",
             $time, words_got, what, got, want);
    err_cnt++;
  endtask

  task automatic add_req(logic req, logic [31:0] seed, bit hold);
    rng_req_t r;
    r.req  = req;
    r.seed = seed;
    r.hold = hold;
    req_q.push_back(r);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(9))
      5:       return $urandom_range(1, 1000);
      6:       return {1'b1, 31'($urandom)};
      7:       return '0;
      8: begin
        case ($urandom_range(3))
          0:       return 32'(GA_MOD);
          1:       return 32'(GB_MOD);
          2:       return 32'(GA_MOD - 1);
          default: return 32'(GB_MOD + 1);
        endcase
      end
      9:       return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic int send_gap_pct();
    if (words_sent < 350) return 22;
    if (words_sent < 700) return 67;
    return 0;
  endfunction

  function automatic int recv_stall_pct();
    if (words_sent < 350) return 67;
    if (words_sent < 700) return 22;
    return 0;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    rng_req_t nxt;
    bit gap, busy;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) words_sent <= words_sent + 1;
      if (!s_axis_tvalid || s_axis_tready) begin
        gap  = ($urandom_range(99) < send_gap_pct());
        busy = (draws_issued != words_got) ||
               (s_axis_tvalid && s_axis_tready &&
                s_axis_tuser == lcgshuf_pkg::REQ_DRAW);
        if (req_q.size() != 0 && !gap && !(req_q[0].hold && busy)) begin
          nxt = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.req;
          s_axis_tdata  <= nxt.seed;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result words, then predicts from accepted requests
  always @(posedge clk_i or negedge rst_ni) begin
    rng_word_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_got <= words_got + 1;
        if (predicted_rand_q.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata[30:0], 0);
        end else begin
          want = predicted_rand_q.pop_front();
          if (m_axis_tdata[30:0] !== want.rand_int)
            report_mismatch("rand_int", m_axis_tdata[30:0], want.rand_int);
          if (m_axis_tdata[62:31] !== want.rand_frac)
            report_mismatch("rand_fraction", m_axis_tdata[62:31], want.rand_frac);
          if (m_axis_tdata[63] !== 1'b0)
            report_mismatch("pad bit", m_axis_tdata[63], 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == lcgshuf_pkg::REQ_DRAW) begin
          predicted_rand_q.push_back(rng_draw());
          draws_issued <= draws_issued + 1;
        end else begin
          rng_reseed(s_axis_tdata);
          reseeds_issued <= reseeds_issued + 1;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct());
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    rng_reseed(1);

    // state after reset is seed 1
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'hffff_ffff, 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    // seeds below one clamp to one
    add_req(lcgshuf_pkg::REQ_RESEED, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_RESEED, 32'h8000_0000, 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_RESEED, 32'hffff_ffff, 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_RESEED, 32'h7fff_ffff, 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    // seed equal to a modulus sticks that generator at zero
    add_req(lcgshuf_pkg::REQ_RESEED, 32'(GA_MOD), 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_RESEED, 32'(GB_MOD), 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);
    add_req(lcgshuf_pkg::REQ_RESEED, 32'd1, 1'b1);
    add_req(lcgshuf_pkg::REQ_DRAW, 32'h0, 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(99) < 6)
        add_req(lcgshuf_pkg::REQ_RESEED, pick_seed(), (i == 330 || i == 680));
      else
        add_req(lcgshuf_pkg::REQ_DRAW, $urandom, (i == 330 || i == 680));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    forever begin
      @(negedge clk_i);
      if (quiet_cycles >= WATCH_LIMIT) begin
        timed_out = 1'b1;
        break;
      end
      if (rst_ni && req_q.size() == 0 && !s_axis_tvalid && predicted_rand_q.size() == 0)
        break;
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk_i);

    if (timed_out) begin
      $display("timeout: no word moved for %0d cycles", WATCH_LIMIT);
      $display("tb_combined_lcg_shuffle_rng_unit: done, errors");
    end else begin
      $display("covered %0d requests: %0d draws, %0d reseeds incl clamped and modulus seeds",
               words_sent, draws_issued, reseeds_issued);
      $display("checked %0d result words under three stall patterns, %0d mismatches",
               words_got, err_cnt);
      if (err_cnt == 0)
        $display("tb_combined_lcg_shuffle_rng_unit: done, clean");
      else
        $display("tb_combined_lcg_shuffle_rng_unit: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
design/lcgshuf_pkg.sv
design/lcgshuf_ram.sv
design/lcgshuf_lehmer.sv
design/lcgshuf_ctrl.sv
design/lcgshuf_dp.sv
design/combined_lcg_shuffle_rng_unit.sv
bench/tb_combined_lcg_shuffle_rng_unit.sv
